FILE: design/imh_pkg.sv
`default_nettype none
package imh_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;

  localparam logic [2:0] KIND_INSERT     = 3'd0;
  localparam logic [2:0] KIND_POP        = 3'd1;
  localparam logic [2:0] KIND_REMOVE_HND = 3'd2;
  localparam logic [2:0] KIND_REPLACE    = 3'd3;
  localparam logic [2:0] KIND_READ       = 3'd4;
  localparam logic [2:0] KIND_REMOVE_IDX = 3'd5;

  typedef struct packed {
    logic [2:0]           kind;
    logic [KEY_WIDTH-1:0] key_in;
    logic [CNT_W-1:0]     handle_in;
    logic [IDX_W-1:0]     heap_index;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [KEY_WIDTH-1:0] key_out;
    logic [CNT_W-1:0]     handle_out;
    logic [KEY_WIDTH-1:0] top_key;
    logic [CNT_W-1:0]     top_handle;
    logic [CNT_W-1:0]     entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_W-1:0]     hnd;
  } node_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_SCAN, OP_SET_P_POS, OP_SET_P_IDX, OP_SET_P_ROOT,
    OP_REMOVE_KEY, OP_REMOVE, OP_LOAD_LAST, OP_LOAD_NEW, OP_READ_KEY,
    OP_MOVE_PARENT, OP_HOLD_LEFT, OP_PICK_RIGHT, OP_MOVE_CHILD, OP_PLACE
  } dp_op_t;

  typedef enum logic [2:0] {
    RD_P, RD_PARENT, RD_LEFT, RD_RIGHT, RD_LAST, RD_ROOT
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       full;
    logic       empty;
    logic       handle_ok;
    logic       idx_ok;
    logic       pos_ok;
    logic       scan_hit;
    logic       p_is_root;
    logic       is_last;
    logic       up_swap;
    logic       down_go;
    logic       has_left;
    logic       has_right;
    logic       child_wins;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN, ST_POS, ST_NODE, ST_TAKE, ST_LAST, ST_REPL,
    ST_READ, ST_SETTLE, ST_UP, ST_DOWN, ST_LEFT, ST_RIGHT, ST_CMP, ST_PLACE,
    ST_TOP, ST_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: design/imh_dp.sv
`default_nettype none
module imh_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire imh_pkg::req_t req,
  input  wire imh_pkg::cmd_t cmd,
  output imh_pkg::status_t   status,
  output imh_pkg::rsp_t      rsp
);

  imh_pkg::node_t node_mem [imh_pkg::CAPACITY];
  logic [imh_pkg::IDX_W-1:0] pos_mem [imh_pkg::CAPACITY];

  imh_pkg::req_t                 rq;
  imh_pkg::node_t                node_rd;
  imh_pkg::node_t                cur;
  imh_pkg::node_t                child;
  logic [imh_pkg::IDX_W-1:0]     pos_rd;
  logic [imh_pkg::IDX_W-1:0]     p;
  logic [imh_pkg::IDX_W-1:0]     child_idx;
  logic [imh_pkg::IDX_W-1:0]     scan;
  logic [imh_pkg::IDX_W-1:0]     last_ptr;
  logic [imh_pkg::CNT_W-1:0]     count;
  logic [imh_pkg::CAPACITY-1:0]  free;
  logic                          ok;
  logic [imh_pkg::KEY_WIDTH-1:0] key_out;
  logic [imh_pkg::CNT_W-1:0]     handle_out;

  logic [imh_pkg::IDX_W-1:0]     rd_addr;
  logic [imh_pkg::IDX_W-1:0]     parent_idx;
  logic [imh_pkg::CNT_W-1:0]     left_idx;
  logic [imh_pkg::CNT_W:0]       right_idx;
  logic [imh_pkg::CNT_W-1:0]     hnd_m1;
  logic [imh_pkg::CNT_W-1:0]     rd_hnd_m1;
  logic [imh_pkg::CNT_W-1:0]     scan_hnd;
  logic                          wr_en;
  imh_pkg::node_t                wr_data;
  logic [imh_pkg::CNT_W-1:0]     wr_hnd_m1;

  assign parent_idx = (p - imh_pkg::IDX_W'(1)) >> 1;
  assign left_idx   = {p, 1'b1};
  assign right_idx  = {1'b0, p, 1'b0} + (imh_pkg::CNT_W+1)'(2);
  assign hnd_m1     = rq.handle_in - imh_pkg::CNT_W'(1);
  assign rd_hnd_m1  = node_rd.hnd - imh_pkg::CNT_W'(1);
  assign scan_hnd   = {1'b0, scan} + imh_pkg::CNT_W'(1);
  assign wr_hnd_m1  = wr_data.hnd - imh_pkg::CNT_W'(1);

  always_comb begin
    case (cmd.rd)
      imh_pkg::RD_P:      rd_addr = p;
      imh_pkg::RD_PARENT: rd_addr = parent_idx;
      imh_pkg::RD_LEFT:   rd_addr = left_idx[imh_pkg::IDX_W-1:0];
      imh_pkg::RD_RIGHT:  rd_addr = right_idx[imh_pkg::IDX_W-1:0];
      imh_pkg::RD_LAST:   rd_addr = imh_pkg::IDX_W'(count - imh_pkg::CNT_W'(1));
      default:            rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = cur;
    case (cmd.op)
      imh_pkg::OP_MOVE_PARENT: begin
        wr_en   = 1'b1;
        wr_data = node_rd;
      end
      imh_pkg::OP_MOVE_CHILD: begin
        wr_en   = 1'b1;
        wr_data = child;
      end
      imh_pkg::OP_PLACE: begin
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    node_rd <= node_mem[rd_addr];
    pos_rd  <= pos_mem[hnd_m1[imh_pkg::IDX_W-1:0]];
    if (wr_en) begin
      node_mem[p]                              <= wr_data;
      pos_mem[wr_hnd_m1[imh_pkg::IDX_W-1:0]] <= p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      free     <= '1;
      last_ptr <= '0;
    end else begin
      case (cmd.op)
        imh_pkg::OP_SCAN: begin
          if (free[scan]) begin
            free[scan] <= 1'b0;
            last_ptr   <= scan + imh_pkg::IDX_W'(1);
            count      <= count + imh_pkg::CNT_W'(1);
          end
        end
        imh_pkg::OP_REMOVE_KEY, imh_pkg::OP_REMOVE: begin
          free[rd_hnd_m1[imh_pkg::IDX_W-1:0]] <= 1'b1;
          count <= count - imh_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      imh_pkg::OP_LATCH: begin
        rq         <= req;
        ok         <= 1'b0;
        key_out    <= '0;
        handle_out <= '0;
        scan       <= last_ptr;
      end
      imh_pkg::OP_SCAN: begin
        if (free[scan]) begin
          handle_out <= scan_hnd;
          cur.key    <= rq.key_in;
          cur.hnd    <= scan_hnd;
          p          <= count[imh_pkg::IDX_W-1:0];
          ok         <= 1'b1;
        end else begin
          scan <= scan + imh_pkg::IDX_W'(1);
        end
      end
      imh_pkg::OP_SET_P_POS:  p <= pos_rd;
      imh_pkg::OP_SET_P_IDX:  p <= rq.heap_index;
      imh_pkg::OP_SET_P_ROOT: p <= '0;
      imh_pkg::OP_REMOVE_KEY: begin
        key_out <= node_rd.key;
        ok      <= 1'b1;
      end
      imh_pkg::OP_REMOVE:     ok <= 1'b1;
      imh_pkg::OP_LOAD_LAST:  cur <= node_rd;
      imh_pkg::OP_LOAD_NEW: begin
        cur.key <= rq.key_in;
        cur.hnd <= rq.handle_in;
        ok      <= 1'b1;
      end
      imh_pkg::OP_READ_KEY: begin
        key_out <= node_rd.key;
        ok      <= 1'b1;
      end
      imh_pkg::OP_MOVE_PARENT: p <= parent_idx;
      imh_pkg::OP_HOLD_LEFT: begin
        child     <= node_rd;
        child_idx <= left_idx[imh_pkg::IDX_W-1:0];
      end
      imh_pkg::OP_PICK_RIGHT: begin
        if (child.key < node_rd.key) begin
          child     <= node_rd;
          child_idx <= right_idx[imh_pkg::IDX_W-1:0];
        end
      end
      imh_pkg::OP_MOVE_CHILD: p <= child_idx;
      default: ;
    endcase
  end

  always_comb begin
    status.kind       = rq.kind;
    status.full       = count == imh_pkg::CNT_W'(imh_pkg::CAPACITY);
    status.empty      = count == '0;
    status.handle_ok  = rq.handle_in != '0
                     && rq.handle_in <= imh_pkg::CNT_W'(imh_pkg::CAPACITY)
                     && !free[hnd_m1[imh_pkg::IDX_W-1:0]];
    status.idx_ok     = {1'b0, rq.heap_index} < count;
    status.pos_ok     = {1'b0, pos_rd} < count;
    status.scan_hit   = free[scan];
    status.p_is_root  = p == '0;
    status.is_last    = {1'b0, p} == count - imh_pkg::CNT_W'(1);
    status.up_swap    = node_rd.key < cur.key;
    status.down_go    = cur.key < node_rd.key;
    status.has_left   = left_idx < count;
    status.has_right  = right_idx < {1'b0, count};
    status.child_wins = cur.key < child.key;
  end

  always_comb begin
    rsp.ok          = ok;
    rsp.key_out     = key_out;
    rsp.handle_out  = handle_out;
    rsp.top_key     = (count != '0) ? node_rd.key : '0;
    rsp.top_handle  = (count != '0) ? node_rd.hnd : '0;
    rsp.entry_count = count;
  end

endmodule
`default_nettype wire

FILE: design/imh_ctrl.sv
`default_nettype none
module imh_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire imh_pkg::status_t status,
  output imh_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  done
);

  imh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = imh_pkg::OP_NONE;
    cmd.rd     = imh_pkg::RD_ROOT;
    busy       = state != imh_pkg::ST_IDLE;
    done       = 1'b0;
    case (state)
      imh_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op     = imh_pkg::OP_LATCH;
          state_next = imh_pkg::ST_DISPATCH;
        end
      end
      imh_pkg::ST_DISPATCH: begin
        state_next = imh_pkg::ST_TOP;
        case (status.kind)
          imh_pkg::KIND_INSERT: begin
            if (!status.full) state_next = imh_pkg::ST_SCAN;
          end
          imh_pkg::KIND_POP: begin
            if (!status.empty) begin
              cmd.op     = imh_pkg::OP_SET_P_ROOT;
              state_next = imh_pkg::ST_NODE;
            end
          end
          imh_pkg::KIND_REMOVE_HND, imh_pkg::KIND_REPLACE, imh_pkg::KIND_READ: begin
            if (status.handle_ok) state_next = imh_pkg::ST_POS;
          end
          imh_pkg::KIND_REMOVE_IDX: begin
            if (status.idx_ok) begin
              cmd.op     = imh_pkg::OP_SET_P_IDX;
              state_next = imh_pkg::ST_NODE;
            end
          end
          default: ;
        endcase
      end
      imh_pkg::ST_SCAN: begin
        cmd.op = imh_pkg::OP_SCAN;
        if (status.scan_hit) state_next = imh_pkg::ST_SETTLE;
      end
      imh_pkg::ST_POS: begin
        if (!status.pos_ok) begin
          state_next = imh_pkg::ST_TOP;
        end else begin
          cmd.op     = imh_pkg::OP_SET_P_POS;
          state_next = (status.kind == imh_pkg::KIND_REPLACE) ? imh_pkg::ST_REPL
                                                              : imh_pkg::ST_NODE;
        end
      end
      imh_pkg::ST_NODE: begin
        cmd.rd     = imh_pkg::RD_P;
        state_next = (status.kind == imh_pkg::KIND_READ) ? imh_pkg::ST_READ
                                                         : imh_pkg::ST_TAKE;
      end
      imh_pkg::ST_TAKE: begin
        cmd.op     = (status.kind == imh_pkg::KIND_REMOVE_HND) ? imh_pkg::OP_REMOVE
                                                               : imh_pkg::OP_REMOVE_KEY;
        cmd.rd     = imh_pkg::RD_LAST;
        state_next = status.is_last ? imh_pkg::ST_TOP : imh_pkg::ST_LAST;
      end
      imh_pkg::ST_LAST: begin
        cmd.op     = imh_pkg::OP_LOAD_LAST;
        state_next = imh_pkg::ST_SETTLE;
      end
      imh_pkg::ST_REPL: begin
        cmd.op     = imh_pkg::OP_LOAD_NEW;
        state_next = imh_pkg::ST_SETTLE;
      end
      imh_pkg::ST_READ: begin
        cmd.op     = imh_pkg::OP_READ_KEY;
        state_next = imh_pkg::ST_TOP;
      end
      imh_pkg::ST_SETTLE: begin
        if (status.p_is_root) begin
          state_next = imh_pkg::ST_DOWN;
        end else begin
          cmd.rd     = imh_pkg::RD_PARENT;
          state_next = imh_pkg::ST_UP;
        end
      end
      imh_pkg::ST_UP: begin
        // move the parent into the hole, or turn down, or settle here
        if (status.up_swap) begin
          cmd.op     = imh_pkg::OP_MOVE_PARENT;
          state_next = imh_pkg::ST_SETTLE;
        end else if (status.down_go) begin
          state_next = imh_pkg::ST_DOWN;
        end else begin
          state_next = imh_pkg::ST_PLACE;
        end
      end
      imh_pkg::ST_DOWN: begin
        if (status.has_left) begin
          cmd.rd     = imh_pkg::RD_LEFT;
          state_next = imh_pkg::ST_LEFT;
        end else begin
          state_next = imh_pkg::ST_PLACE;
        end
      end
      imh_pkg::ST_LEFT: begin
        cmd.op = imh_pkg::OP_HOLD_LEFT;
        if (status.has_right) begin
          cmd.rd     = imh_pkg::RD_RIGHT;
          state_next = imh_pkg::ST_RIGHT;
        end else begin
          state_next = imh_pkg::ST_CMP;
        end
      end
      imh_pkg::ST_RIGHT: begin
        cmd.op     = imh_pkg::OP_PICK_RIGHT;
        state_next = imh_pkg::ST_CMP;
      end
      imh_pkg::ST_CMP: begin
        if (status.child_wins) begin
          cmd.op     = imh_pkg::OP_MOVE_CHILD;
          state_next = imh_pkg::ST_DOWN;
        end else begin
          state_next = imh_pkg::ST_PLACE;
        end
      end
      imh_pkg::ST_PLACE: begin
        cmd.op     = imh_pkg::OP_PLACE;
        state_next = imh_pkg::ST_TOP;
      end
      imh_pkg::ST_TOP: begin
        cmd.rd     = imh_pkg::RD_ROOT;
        state_next = imh_pkg::ST_EMIT;
      end
      imh_pkg::ST_EMIT: begin
        done       = 1'b1;
        state_next = imh_pkg::ST_IDLE;
      end
      default: state_next = imh_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/indexed_max_heap_with_handles.sv
// One transaction at a time: busy from acceptance through the result strobe; the next
// transaction can be accepted in the cycle after the strobe.
// Failed requests, reads and removals of the last node move no node. Other removals,
// replaces and inserts move the entry up or down one level at a time (up to 6 levels,
// one node-memory read port); insert first scans for a free handle. Result on done for
// one cycle, no stall; sync reset empties the heap.
`default_nettype none
module indexed_max_heap_with_handles (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire imh_pkg::req_t req,
  output logic               done,
  output imh_pkg::rsp_t      rsp
);

  imh_pkg::cmd_t    cmd;
  imh_pkg::status_t status;

  imh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  imh_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.entry_count <= imh_pkg::CNT_W'(imh_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    done && rsp.entry_count == '0 |-> rsp.top_handle == '0 && rsp.top_key == '0)
    else $error("empty heap shows a top entry");

endmodule
`default_nettype wire
